// File: src/thd_pkg.sv
package thd_pkg;

	// Result event codes
	typedef enum logic [1:0] {
		EV_NONE  = 2'd0,
		EV_BEGIN = 2'd1,
		EV_END   = 2'd2
	} event_t;

	// Register indexes (byte address = 4 * index)
	typedef enum logic [1:0] {
		REG_VOICE_HANG = 2'd0,
		REG_TONE_HANG  = 2'd1,
		REG_TONE_GRACE = 2'd2,
		REG_TRUST      = 2'd3
	} reg_idx_t;

	localparam int HANG_W    = 16;
	localparam int READING_W = 2;

	// Carrier reading codes (2-bit signed field)
	localparam logic [READING_W-1:0] RD_ABSENT  = 2'b00;
	localparam logic [READING_W-1:0] RD_PRESENT = 2'b01;

	typedef struct packed {
		logic [HANG_W-1:0] voice_hang;
		logic [HANG_W-1:0] tone_hang;
		logic [HANG_W-1:0] tone_grace;
		logic              trust_carrier;
	} cfg_t;

endpackage

// File: src/tx_activity_hang_detector_top.sv
// Transmit-activity detector with hang timer.
// Input stream (s_*): one item per tick: carrier reading (2-bit signed,
//   -1/-2 = no data) and tone flag. Output stream (m_*): exactly one result
//   item per input item: event (none/begin/end) and the hang threshold that
//   was selected on that tick.
// Output: the result is registered and appears on m_tvalid in the cycle after
//   the input item is accepted. Throughput: one item per clock unless the
//   receiver stalls; all per-tick work is a short counter/compare path.
// Backpressure: s_tready = !m_tvalid | m_tready, so a new item is taken in
//   the same cycle the pending result drains; while the receiver stalls the
//   result register holds and no input is taken.
// Configuration: APB, registers at 0x0 voice hang, 0x4 tone hang, 0x8 tone
//   grace, 0xC trust carrier. Write only while the stream is idle; new
//   values act from the next item. pready is always high.
// Reset (arst_n low): registers cleared, held carrier 0, ticks-since-tone
//   saturated ("long ago"), silent count 0, not published, no result pending.
module tx_activity_hang_detector_top import thd_pkg::*; #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// APB configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// input items
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [1:0] carrier_reading, [2] tone_present, rest zero
	// result items
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata    // [1:0] event_res, [17:2] hang_in_use, rest zero
);

	cfg_t              cfg_q;
	logic              s_accept;
	logic              cfg_wr;
	reg_idx_t          reg_idx;
	event_t            ev;
	logic [HANG_W-1:0] hang;
	event_t            ev_q;
	logic [HANG_W-1:0] hang_q;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_VOICE_HANG: cfg_q.voice_hang    <= pwdata[HANG_W-1:0];
				REG_TONE_HANG:  cfg_q.tone_hang     <= pwdata[HANG_W-1:0];
				REG_TONE_GRACE: cfg_q.tone_grace    <= pwdata[HANG_W-1:0];
				REG_TRUST:      cfg_q.trust_carrier <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_VOICE_HANG: prdata = 32'(cfg_q.voice_hang);
			REG_TONE_HANG:  prdata = 32'(cfg_q.tone_hang);
			REG_TONE_GRACE: prdata = 32'(cfg_q.tone_grace);
			REG_TRUST:      prdata = 32'(cfg_q.trust_carrier);
			default:        prdata = '0;
		endcase
	end

	assign s_tready = !m_tvalid || m_tready;
	assign s_accept = s_tvalid && s_tready;

	thd_core #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (s_accept),
		.carrier_reading(s_tdata[1:0]),
		.tone_present   (s_tdata[2]),
		.cfg            (cfg_q),
		.event_res      (ev),
		.hang_in_use    (hang)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (s_accept) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			ev_q   <= ev;
			hang_q <= hang;
		end
	end

	assign m_tdata = {6'b0, hang_q, ev_q};

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_accept)
		else $error("input taken while result stalled");

	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_accept |=> m_tvalid)
		else $error("accepted item produced no result");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(ev_q) && $stable(hang_q))
		else $error("stalled result changed");

endmodule

// File: src/thd_core.sv
module thd_core import thd_pkg::*; #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic signed [READING_W-1:0] carrier_reading,
	input  logic                 tone_present,
	input  cfg_t                 cfg,
	output event_t               event_res,
	output logic [HANG_W-1:0]    hang_in_use
);

	localparam int CMP_W = (COUNT_WIDTH > HANG_W) ? COUNT_WIDTH : HANG_W;
	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

	logic                   carrier_q;
	logic [COUNT_WIDTH-1:0] tick_q;
	logic [COUNT_WIDTH-1:0] silent_q;
	logic                   published_q;

	logic                   carrier_d;
	logic [COUNT_WIDTH-1:0] tick_d;
	logic [COUNT_WIDTH-1:0] silent_inc;
	logic [COUNT_WIDTH-1:0] silent_d;
	logic                   published_d;
	logic [HANG_W-1:0]      tone_hang_eff;
	logic                   active;

	always_comb begin
		// held carrier: only definite readings update it; trust off forces zero
		carrier_d = carrier_q;
		if (!cfg.trust_carrier) begin
			carrier_d = 1'b0;
		end else if (carrier_reading == RD_ABSENT || carrier_reading == RD_PRESENT) begin
			carrier_d = carrier_reading[0];
		end

		if (tone_present) begin
			tick_d = '0;
		end else if (tick_q != CNT_MAX) begin
			tick_d = tick_q + 1'b1;
		end else begin
			tick_d = tick_q;
		end

		tone_hang_eff = (cfg.tone_hang < cfg.voice_hang) ? cfg.voice_hang : cfg.tone_hang;
		hang_in_use = (CMP_W'(tick_d) < CMP_W'(cfg.tone_grace)) ? tone_hang_eff
		                                                        : cfg.voice_hang;

		active      = carrier_d | tone_present;
		silent_inc  = (silent_q != CNT_MAX) ? silent_q + 1'b1 : silent_q;
		silent_d    = silent_q;
		published_d = published_q;
		event_res   = EV_NONE;
		if (active) begin
			silent_d = '0;
			if (!published_q) begin
				published_d = 1'b1;
				event_res   = EV_BEGIN;
			end
		end else if (published_q) begin
			if (CMP_W'(silent_inc) >= CMP_W'(hang_in_use)) begin
				published_d = 1'b0;
				silent_d    = '0;
				event_res   = EV_END;
			end else begin
				silent_d = silent_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carrier_q   <= 1'b0;
			tick_q      <= CNT_MAX;
			silent_q    <= '0;
			published_q <= 1'b0;
		end else if (step) begin
			carrier_q   <= carrier_d;
			tick_q      <= tick_d;
			silent_q    <= silent_d;
			published_q <= published_d;
		end
	end

	a_end_needs_pub: assert property (@(posedge clk) disable iff (!arst_n)
		step && event_res == EV_END |-> published_q)
		else $error("END without published state");

	a_begin_sets_pub: assert property (@(posedge clk) disable iff (!arst_n)
		step && event_res == EV_BEGIN |=> published_q)
		else $error("BEGIN did not set published");

	a_idle_silent_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!published_q |-> silent_q == '0)
		else $error("silent count nonzero while not published");

	a_tone_clears_tick: assert property (@(posedge clk) disable iff (!arst_n)
		step && tone_present |=> tick_q == '0)
		else $error("tone did not clear tick counter");

endmodule

// File: bench/tb_top.sv
module tb_top;
	import thd_pkg::*;

	localparam int CNT_W = 16;
	localparam logic [CNT_W-1:0] CNT_SAT = {CNT_W{1'b1}};

	// carrier reading codes the package leaves unnamed: -1 is "no data",
	// -2 is the unused code, also taken as "no data"
	localparam logic [READING_W-1:0] RD_NODATA = 2'b11;
	localparam logic [READING_W-1:0] RD_UNUSED = 2'b10;

	typedef struct packed {
		logic [READING_W-1:0] reading;
		logic                 tone;
	} tick_t;

	typedef struct packed {
		event_t            ev;
		logic [HANG_W-1:0] hang;
	} verdict_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;    // [1:0] carrier_reading, [2] tone_present, rest zero
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;         // [1:0] event_res, [17:2] hang_in_use, rest zero

	tx_activity_hang_detector_top #(
		.COUNT_WIDTH(CNT_W)
	) DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	// 12-unit period
	always begin
		#6 clk = 1'b1;
		#6 clk = 0;
	end

	// hard stop, many times the slowest legal run
	initial begin
		#(12 * 200_000);
		$display("FAIL");
		$finish;
	end

	// ---------------------------------------------------------------
	// Shadow of the block: registers and per-tick state
	// ---------------------------------------------------------------
	logic [HANG_W-1:0] cfg_voice = '0;
	logic [HANG_W-1:0] cfg_tone  = '0;
	logic [HANG_W-1:0] cfg_grace = '0;
	logic              cfg_trust = 1'b0;

	logic              carrier_held = 1'b0;
	logic [CNT_W-1:0]  since_tone   = CNT_SAT;   // "long ago" after reset
	logic [CNT_W-1:0]  quiet_run    = '0;
	logic              on_air       = 1'b0;

	// One tick of the squelch: held carrier, tone age, hang pick, begin/end.
	function automatic verdict_t squelch_tick(tick_t t);
		logic [HANG_W-1:0] long_hang;
		verdict_t v;
		if (cfg_trust) begin
			// both "no data" codes keep the last definite reading
			if (t.reading == RD_ABSENT || t.reading == RD_PRESENT)
				carrier_held = t.reading[0];
		end else begin
			carrier_held = 1'b0;
		end

		if (t.tone)
			since_tone = '0;
		else if (since_tone != CNT_SAT)
			since_tone = since_tone + 1'b1;

		// tone hang never drops below the voice hang
		long_hang = (cfg_tone < cfg_voice) ? cfg_voice : cfg_tone;
		v.hang = (since_tone < cfg_grace) ? long_hang : cfg_voice;
		v.ev = EV_NONE;

		if (carrier_held || t.tone) begin
			quiet_run = '0;
			if (!on_air) begin
				on_air = 1'b1;
				v.ev = EV_BEGIN;
			end
		end else if (on_air) begin
			if (quiet_run != CNT_SAT)
				quiet_run = quiet_run + 1'b1;
			// zero hang ends on the first silent tick
			if (quiet_run >= v.hang) begin
				on_air = 1'b0;
				quiet_run = '0;
				v.ev = EV_END;
			end
		end
		return v;
	endfunction

	// ---------------------------------------------------------------
	// Stream state shared by driver, receiver and monitor
	// ---------------------------------------------------------------
	tick_t    tick_feed[$];        // items waiting to go out
	verdict_t pending_verdicts[$]; // predicted results, oldest first
	logic     in_taken  = 1'b0;    // input handshake at the last rising edge
	logic     out_taken = 1'b0;    // output handshake at the last rising edge
	bit       no_idle   = 1'b0;    // both sides run back to back
	int       send_gap  = 0;
	int       hold_off  = 0;
	int       fail_cnt  = 0;
	int       ticks_in  = 0;
	int       results   = 0;
	int       begins    = 0;
	int       ends      = 0;
	int       settings  = 0;

	// Driver: presents items at the falling edge, holds until taken,
	// then waits a drawn gap before the next one.
	always @(negedge clk) begin
		tick_t t;
		if (arst_n) begin
			if (s_tvalid && !in_taken) begin
				// item still on the bus
			end else if (send_gap > 0) begin
				s_tvalid <= 1'b0;
				send_gap--;
			end else if (tick_feed.size() > 0) begin
				t = tick_feed.pop_front();
				s_tdata  <= {5'b0, t.tone, t.reading};
				s_tvalid <= 1'b1;
				send_gap = no_idle ? 0 : $urandom_range(0, 3);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: after each taken result, stall a drawn number of cycles.
	always @(negedge clk) begin
		if (arst_n) begin
			if (out_taken)
				hold_off = no_idle ? 0 : $urandom_range(0, 3);
			if (hold_off > 0) begin
				m_tready <= 1'b0;
				hold_off--;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	function automatic void report(string what, int unsigned want, int unsigned got);
		fail_cnt++;
		if (fail_cnt <= 10)
			$display("mismatch %s at result %0d: expected %0h, got %0h",
				what, results, want, got);
	endfunction

	// Monitor: predict on every input handshake, check every output one.
	always @(posedge clk) begin
		verdict_t want;
		verdict_t got;
		if (arst_n) begin
			in_taken  <= s_tvalid && s_tready;
			out_taken <= m_tvalid && m_tready;
			if (s_tvalid && s_tready) begin
				pending_verdicts.push_back(squelch_tick(tick_t'({s_tdata[1:0], s_tdata[2]})));
				ticks_in++;
			end
			if (m_tvalid && m_tready) begin
				got.ev   = event_t'(m_tdata[1:0]);
				got.hang = m_tdata[17:2];
				if (got.ev == EV_BEGIN)
					begins++;
				if (got.ev == EV_END)
					ends++;
				if (pending_verdicts.size() == 0) begin
					report("unexpected result", 0, m_tdata);
				end else begin
					want = pending_verdicts.pop_front();
					if (got.ev != want.ev)
						report("event_res", want.ev, got.ev);
					if (got.hang != want.hang)
						report("hang_in_use", want.hang, got.hang);
				end
				results++;
			end
		end
	end

	// ---------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------
	task automatic push_tick(logic [READING_W-1:0] rd, logic tone);
		tick_t t;
		t.reading = rd;
		t.tone = tone;
		tick_feed.push_back(t);
	endtask

	// Block idle: everything sent, every result back. Each item's result is
	// registered in the cycle after it is taken, so a short tail is enough.
	task automatic settle();
		while (tick_feed.size() > 0 || s_tvalid || pending_verdicts.size() > 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// APB write: setup, then access; the write lands at the access edge.
	task automatic reg_write(reg_idx_t idx, logic [31:0] val);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {idx, 2'b00};
		pwdata  = val;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		case (idx)
			REG_VOICE_HANG: cfg_voice = val[HANG_W-1:0];
			REG_TONE_HANG:  cfg_tone  = val[HANG_W-1:0];
			REG_TONE_GRACE: cfg_grace = val[HANG_W-1:0];
			REG_TRUST:      cfg_trust = val[0];
		endcase
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	task automatic set_squelch(logic [15:0] voice, logic [15:0] tone,
			logic [15:0] grace, logic trust);
		reg_write(REG_VOICE_HANG, {16'b0, voice});
		reg_write(REG_TONE_HANG, {16'b0, tone});
		reg_write(REG_TONE_GRACE, {16'b0, grace});
		reg_write(REG_TRUST, {31'b0, trust});
		settings++;
	endtask

	function automatic logic [15:0] pick_hang();
		case ($urandom_range(0, 9))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom_range(1, 12));
		endcase
	endfunction

	// Mostly talk bursts and silent runs of up to the larger hang (capped at 12)
	// plus two ticks, with some noise mixed in.
	task automatic gen_traffic(int n);
		int left;
		int len;
		int run_len;
		int kind;
		run_len = (cfg_tone > cfg_voice) ? cfg_tone : cfg_voice;
		if (run_len > 12)
			run_len = 12;
		left = n;
		while (left > 0) begin
			kind = $urandom_range(0, 9);
			if (kind < 4) begin
				len = $urandom_range(1, 5);
				repeat (len) begin
					if ($urandom_range(0, 1))
						push_tick(RD_PRESENT, 1'($urandom_range(0, 1)));
					else
						push_tick(2'($urandom_range(0, 3)), 1'b1);
				end
			end else if (kind < 8) begin
				len = $urandom_range(0, run_len + 2);
				repeat (len) begin
					case ($urandom_range(0, 2))
						0: push_tick(RD_ABSENT, 1'b0);
						1: push_tick(RD_NODATA, 1'b0);
						default: push_tick(RD_UNUSED, 1'b0);
					endcase
				end
			end else begin
				len = $urandom_range(1, 4);
				repeat (len) push_tick(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
			end
			left -= len;
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		#3 arst_n = 1'b1;

		// Reset settings: trust off, all hangs zero. Carrier is ignored, a
		// tone begins, the first silent tick ends.
		push_tick(RD_PRESENT, 1'b0);
		push_tick(RD_NODATA, 1'b0);
		push_tick(RD_ABSENT, 1'b1);
		push_tick(RD_ABSENT, 1'b0);
		push_tick(RD_UNUSED, 1'b1);
		push_tick(RD_PRESENT, 1'b1);
		push_tick(RD_PRESENT, 1'b0);
		settle();

		// Trusted carrier, both no-data codes hold it, tone hang inside the
		// grace window then voice hang once the window closes.
		set_squelch(16'd3, 16'd6, 16'd4, 1'b1);
		push_tick(RD_PRESENT, 1'b0);
		push_tick(RD_NODATA, 1'b0);
		push_tick(RD_UNUSED, 1'b0);
		push_tick(RD_ABSENT, 1'b0);
		push_tick(RD_NODATA, 1'b0);
		push_tick(RD_UNUSED, 1'b0);
		push_tick(RD_ABSENT, 1'b1);
		repeat (6) push_tick(RD_ABSENT, 1'b0);
		settle();

		// Tone hang below voice hang: voice wins.
		set_squelch(16'd5, 16'd0, 16'hFFFF, 1'b1);
		push_tick(RD_ABSENT, 1'b1);
		repeat (6) push_tick(RD_ABSENT, 1'b0);
		settle();

		// Random phases; the first forces a closed grace window, the second
		// trust off.
		for (int k = 0; k < 8; k++) begin
			set_squelch(pick_hang(), pick_hang(),
				(k == 0) ? 16'd0 : pick_hang(),
				(k == 1) ? 1'b0 : 1'($urandom_range(0, 3) != 0));
			no_idle = ($urandom_range(0, 3) == 0);
			gen_traffic(135);
			settle();  // sender holds off until every result is back
		end

		// Longest hang, back to back: a silent run far below it never ends
		// the activity.
		no_idle = 1'b1;
		set_squelch(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
		push_tick(RD_ABSENT, 1'b1);
		repeat (40) push_tick(RD_ABSENT, 1'b0);
		settle();

		// Widest grace window: the tone hang stays picked long after the
		// last tone, while the activity is still on from the phase above.
		no_idle = 1'b0;
		set_squelch(16'd2, 16'd9, 16'hFFFF, 1'b1);
		push_tick(RD_PRESENT, 1'b0);
		repeat (3) push_tick(RD_ABSENT, 1'b0);
		gen_traffic(60);
		settle();

		$display("Covered %0d ticks under %0d register settings: %0d begin, %0d end events.",
			ticks_in, settings, begins, ends);
		if (fail_cnt == 0) begin
			$display("PASS");
		end else begin
			$display("%0d mismatches in total", fail_cnt);
			$display("FAIL");
		end
		$finish;
	end

endmodule
